@@ hw/rtl/spq_pkg.sv @@
// shared types and constants of the sorted priority queue
package spq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int PRI_W = 8;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;
	localparam int OCC_W = 5;
	localparam int IN_DATA_W = ((VAL_W + PRI_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((VAL_W + PRI_W + OCC_W + 7) / 8) * 8;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic insert;
		logic delete;
		logic signed [VAL_W-1:0] value;
		logic [PRI_W-1:0] prio;
	} spq_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic full;
		logic empty;
		logic signed [VAL_W-1:0] head_value;
		logic [PRI_W-1:0] head_prio;
	} spq_stat_t;

endpackage

@@ hw/rtl/spq_datapath.sv @@
// sorted shift-register cell chain holding the queue entries
module spq_datapath import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  spq_cmd_t cmd,
	output spq_stat_t stat
);

	logic signed [VAL_W-1:0] val_q [DEPTH];
	logic [PRI_W-1:0] pri_q [DEPTH];
	logic [CNT_W-1:0] count_q;

	logic signed [VAL_W-1:0] val_d [DEPTH];
	logic [PRI_W-1:0] pri_d [DEPTH];
	logic [DEPTH-1:0] le;
	logic [DEPTH-1:0] le_prev;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			le[i] = (CNT_W'(i) < count_q) && (pri_q[i] <= cmd.prio);
		end
		le_prev = {le[DEPTH-2:0], 1'b1};
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			val_d[i] = val_q[i];
			pri_d[i] = pri_q[i];
		end
		if (cmd.insert) begin
			for (int i = 1; i < DEPTH; i++) begin
				if (!le[i] && !le_prev[i]) begin
					val_d[i] = val_q[i-1];
					pri_d[i] = pri_q[i-1];
				end
			end
			for (int i = 0; i < DEPTH; i++) begin
				if (!le[i] && le_prev[i]) begin
					val_d[i] = cmd.value;
					pri_d[i] = cmd.prio;
				end
			end
		end else if (cmd.delete) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				val_d[i] = val_q[i+1];
				pri_d[i] = pri_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			val_q[i] <= val_d[i];
			pri_q[i] <= pri_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.delete) begin
			count_q <= count_q - 1'b1;
		end
	end

	assign stat.count = count_q;
	assign stat.full = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.head_value = val_q[0];
	assign stat.head_prio = pri_q[0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> (count_q != CNT_W'(DEPTH)) && !cmd.delete)
		else $error("insert into full queue or together with delete");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.delete |-> (count_q != '0))
		else $error("delete from empty queue");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > CNT_W'(1)) |-> (pri_q[0] <= pri_q[1]))
		else $error("head entry out of order");

endmodule

@@ hw/rtl/spq_ctrl.sv @@
// controller: handshake, operation decode and result register
module spq_ctrl import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [KIND_W-1:0] in_kind,
	input  logic signed [VAL_W-1:0] in_value,
	input  logic [PRI_W-1:0] in_prio,
	output logic out_valid,
	input  logic out_ready,
	output logic [STAT_W-1:0] out_status,
	output logic signed [VAL_W-1:0] out_value,
	output logic [PRI_W-1:0] out_prio,
	output logic [OCC_W-1:0] out_occ,
	output spq_cmd_t cmd,
	input  spq_stat_t stat
);

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	state_t state_q;
	logic accept;
	logic [STAT_W-1:0] res_status;
	logic signed [VAL_W-1:0] res_value;
	logic [PRI_W-1:0] res_prio;
	logic [CNT_W-1:0] res_count;

	assign in_ready = (state_q == S_IDLE) || out_ready;
	assign accept = in_valid && in_ready;
	assign out_valid = (state_q == S_HOLD);

	always_comb begin
		cmd.insert = 1'b0;
		cmd.delete = 1'b0;
		cmd.value = in_value;
		cmd.prio = in_prio;
		res_status = ST_OK;
		res_value = '0;
		res_prio = '0;
		res_count = stat.count;
		unique case (in_kind)
			KIND_INSERT: begin
				if (stat.full) begin
					res_status = ST_FULL;
				end else begin
					cmd.insert = accept;
					res_count = stat.count + 1'b1;
				end
			end
			KIND_DELETE, KIND_PEEK: begin
				if (stat.empty) begin
					res_status = ST_EMPTY;
				end else begin
					res_value = stat.head_value;
					res_prio = stat.head_prio;
					if (in_kind == KIND_DELETE) begin
						cmd.delete = accept;
						res_count = stat.count - 1'b1;
					end
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_status <= ST_OK;
			out_value <= '0;
			out_prio <= '0;
			out_occ <= '0;
		end else begin
			if (accept) begin
				state_q <= S_HOLD;
				out_status <= res_status;
				out_value <= res_value;
				out_prio <= res_prio;
				out_occ <= OCC_W'(res_count);
			end else if (out_ready) begin
				state_q <= S_IDLE;
			end
		end
	end

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status != ST_OK) |-> (out_value == '0) && (out_prio == '0))
		else $error("failed operation returned head data");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status == ST_FULL) |-> (out_occ == OCC_W'(DEPTH)))
		else $error("full report with queue not full");

	a_occ_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (out_occ == OCC_W'(stat.count)))
		else $error("reported occupancy differs from stored count");

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// top level of the sorted priority queue
//
// input words on the s_ side: s_tuser carries the operation (insert, delete
// head, peek head), s_tdata the item value and priority used by an insert
// every accepted word gives exactly one result word on the m_ side, carrying
// the status in m_tuser and head value, head priority and occupancy in m_tdata
// smaller priority numbers leave first, equal priorities in arrival order
// an insert into a full queue is dropped with a full status, a delete or peek
// on an empty queue returns an empty status with zero head fields
// m_tvalid rises in the cycle after input accept; one word per cycle is
// taken while the result register is empty or being read in the same cycle,
// set by the compare and shift of the entry cell chain
// when the receiver stalls, the result word holds and s_tready drops until
// m_tready returns
// reset empties the queue and clears m_tvalid; no clearing pass is needed
module sorted_priority_queue import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,    // item_value, item_priority
	input  logic [KIND_W-1:0] s_tuser,       // kind
	output logic m_tvalid,
	input  logic m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // head_value, head_priority, occupancy, zero pad
	output logic [STAT_W-1:0] m_tuser        // status
);

	spq_cmd_t cmd;
	spq_stat_t stat;
	logic signed [VAL_W-1:0] out_value;
	logic [PRI_W-1:0] out_prio;
	logic [OCC_W-1:0] out_occ;

	spq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_kind(s_tuser),
		.in_value(s_tdata[VAL_W-1:0]),
		.in_prio(s_tdata[VAL_W+PRI_W-1:VAL_W]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_status(m_tuser),
		.out_value(out_value),
		.out_prio(out_prio),
		.out_occ(out_occ),
		.cmd(cmd),
		.stat(stat)
	);

	spq_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat)
	);

	assign m_tdata = {{(OUT_DATA_W-VAL_W-PRI_W-OCC_W){1'b0}}, out_occ, out_prio, out_value};

endmodule
